[hw/rtl/rssd_pkg.sv]
// package: shared types, constants and opcodes for the sprite span darkener
package rssd_pkg;
  localparam int SPRITE_WORDS = 65536;
  localparam int MAX_ROWS = 1024;
  localparam int AW = $clog2(SPRITE_WORDS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam logic [15:0] DARK_MASK = 16'he79c;
  localparam logic [11:0] COUNT_MAX = 12'hfff;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_DARKEN = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_WRITTEN = 3'd0,
    ST_READ    = 3'd1,
    ST_DARK    = 3'd2,
    ST_BADROW  = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_MARKED  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_WIDTH   = 2'd0,
    CFG_HEIGHT  = 2'd1,
    CFG_PRESENT = 2'd2
  } cfg_idx_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0]    kind;   // 0 word op, 1 immediate status, 2 walk
    opcode_t       op;
    status_t       status;
    logic [AW-1:0] addr;
    logic [15:0]   data;
    logic [RW-1:0] row;
    logic [12:0]   x;
    logic [12:0]   w;
  } job_t;

  localparam logic [1:0] K_WORD = 2'd0;
  localparam logic [1:0] K_IMM  = 2'd1;
  localparam logic [1:0] K_WALK = 2'd2;

  typedef enum logic [1:0] {
    F_CLEAR, F_IDLE, F_LOOK
  } fstate_t;

  typedef enum logic [3:0] {
    B_IDLE, B_WORD, B_RDOUT, B_ROWSZ, B_ROWSTEP, B_NSEG, B_SEGST, B_SEGCNT,
    B_SEGDEC, B_PXRD, B_PXWR, B_DONE
  } bstate_t;
endpackage

[hw/rtl/rssd_front.sv]
// front: classifies items, clips spans and keeps the row marks
module rssd_front import rssd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    opcode,
  input  logic [15:0]   word_addr,
  input  logic [15:0]   word_data,
  input  logic [11:0]   row_index,
  input  logic [12:0]   x_start,
  input  logic [12:0]   span_width,
  input  logic [11:0]   field_width,
  input  logic [10:0]   field_height,
  input  logic          sprite_present,
  output logic          job_valid,
  output job_t          job
);
  logic marks_mem [MAX_ROWS];
  logic mark_rd_r;
  logic m_we, m_din;
  logic [RW-1:0] m_addr;
  fstate_t fst_r, fst_nxt;
  logic [RW-1:0] clr_r, clr_nxt;
  job_t job_r, job_nxt, job_c;
  logic cand_r, cand_nxt, cand_c;
  logic signed [14:0] x0, w0, w1, xe;
  logic bad;

  always_ff @(posedge clk) begin
    if (m_we) marks_mem[m_addr] <= m_din;
    mark_rd_r <= marks_mem[row_index[RW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r <= F_CLEAR;
      clr_r <= '0;
    end else begin
      fst_r <= fst_nxt;
      clr_r <= clr_nxt;
    end
    job_r <= job_nxt;
    cand_r <= cand_nxt;
  end

  always_comb begin
    job_c = '0;
    job_c.op = opcode_t'(opcode);
    job_c.addr = word_addr[AW-1:0];
    job_c.data = word_data;
    job_c.row = row_index[RW-1:0];
    cand_c = 1'b0;
    bad = row_index[11] || ({1'b0, row_index} >= {2'b0, field_height}) ||
          ({1'b0, row_index} >= 13'(MAX_ROWS));
    x0 = 15'(signed'(x_start));
    w0 = 15'(signed'(span_width));
    if (x0 < 0) begin
      w0 = w0 + x0;
      x0 = '0;
    end
    xe = x0 + w0;
    w1 = w0;
    if ($signed({3'b0, field_width}) < xe) w1 = $signed({3'b0, field_width}) - x0;
    job_c.x = x0[12:0];
    job_c.w = w1[12:0];
    if (opcode == OP_WRITE || opcode == OP_READ) begin
      job_c.kind = K_WORD;
    end else begin
      job_c.kind = K_IMM;
      if (bad) job_c.status = ST_BADROW;
      else if (w1 <= 0) job_c.status = ST_EMPTY;
      else begin
        job_c.status = ST_DARK;
        cand_c = 1'b1;
        if (sprite_present) job_c.kind = K_WALK;
      end
    end
  end

  always_comb begin
    fst_nxt = fst_r; clr_nxt = clr_r; job_nxt = job_r; cand_nxt = cand_r;
    in_ready = 1'b0; job_valid = 1'b0; job = job_r;
    m_we = 1'b0; m_addr = job_r.row; m_din = 1'b1;
    case (fst_r)
      F_CLEAR: begin
        m_we = 1'b1; m_addr = clr_r; m_din = 1'b0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == RW'(MAX_ROWS - 1)) fst_nxt = F_IDLE;
      end
      F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && opcode != OP_NONE) begin
          job_nxt = job_c;
          cand_nxt = cand_c;
          fst_nxt = F_LOOK;
        end
      end
      F_LOOK: begin
        job_valid = 1'b1;
        if (cand_r) begin
          if (mark_rd_r) begin
            job.kind = K_IMM;
            job.status = ST_MARKED;
          end else begin
            m_we = 1'b1;
          end
        end
        fst_nxt = F_IDLE;
      end
      default: fst_nxt = F_IDLE;
    endcase
  end
endmodule

[hw/rtl/rssd_back.sv]
// back: sprite memory and the row and segment walker
module rssd_back import rssd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  job_t          job,
  output logic          job_ready,
  output logic          out_valid,
  output logic [2:0]    out_status,
  output logic [15:0]   out_read_data,
  output logic [11:0]   out_pixels_changed
);
  logic [15:0] mem [SPRITE_WORDS];
  logic [15:0] rdata_r;
  logic [AW-1:0] raddr;
  logic wen;
  logic [AW-1:0] waddr;
  logic [15:0] wdata;

  bstate_t st_r, st_nxt;
  job_t j_r, j_nxt;
  logic [AW-1:0] p_r, p_nxt, dst_r, dst_nxt;
  logic [RW-1:0] rcnt_r, rcnt_nxt;
  logic [15:0] nseg_r, nseg_nxt, start_r, start_nxt, n_r, n_nxt;
  logic [11:0] done_r, done_nxt;
  logic ov_r, ov_nxt;
  logic [2:0] os_r, os_nxt;
  logic [15:0] od_r, od_nxt;
  logic [11:0] oc_r, oc_nxt;

  logic signed [17:0] sx, sw, ss, sc, se, sn, left;

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
    j_r <= j_nxt; p_r <= p_nxt; dst_r <= dst_nxt; rcnt_r <= rcnt_nxt;
    nseg_r <= nseg_nxt; start_r <= start_nxt; n_r <= n_nxt; done_r <= done_nxt;
    os_r <= os_nxt; od_r <= od_nxt; oc_r <= oc_nxt;
  end

  assign out_valid = ov_r;
  assign out_status = os_r;
  assign out_read_data = od_r;
  assign out_pixels_changed = oc_r;

  always_comb begin
    st_nxt = st_r; j_nxt = j_r; p_nxt = p_r; dst_nxt = dst_r; rcnt_nxt = rcnt_r;
    nseg_nxt = nseg_r; start_nxt = start_r; n_nxt = n_r; done_nxt = done_r;
    ov_nxt = 1'b0; os_nxt = os_r; od_nxt = od_r; oc_nxt = oc_r;
    raddr = p_r; wen = 1'b0; waddr = dst_r; wdata = (rdata_r & DARK_MASK) >> 2;
    job_ready = 1'b0;
    sx = 18'(j_r.x); sw = 18'(j_r.w);
    ss = $signed({2'b0, start_r}); sc = $signed({2'b0, rdata_r});
    se = ss + sc; sn = '0; left = sw + (sx - ss);
    case (st_r)
      B_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          j_nxt = job;
          p_nxt = '0;
          rcnt_nxt = job.row;
          done_nxt = '0;
          case (job.kind)
            K_WORD: st_nxt = B_WORD;
            K_WALK: st_nxt = (job.row == '0) ? B_NSEG : B_ROWSZ;
            default: begin
              ov_nxt = 1'b1; os_nxt = job.status; od_nxt = '0; oc_nxt = '0;
            end
          endcase
        end
      end
      B_WORD: begin
        raddr = j_r.addr;
        if (j_r.op == OP_WRITE) begin
          wen = 1'b1; waddr = j_r.addr; wdata = j_r.data;
          ov_nxt = 1'b1; os_nxt = ST_WRITTEN; od_nxt = '0; oc_nxt = '0;
          st_nxt = B_IDLE;
        end else begin
          st_nxt = B_RDOUT;
        end
      end
      B_RDOUT: begin
        ov_nxt = 1'b1; os_nxt = ST_READ; od_nxt = rdata_r; oc_nxt = '0;
        st_nxt = B_IDLE;
      end
      B_ROWSZ: begin
        raddr = p_r; st_nxt = B_ROWSTEP;
      end
      B_ROWSTEP: begin
        p_nxt = p_r + AW'(rdata_r);
        rcnt_nxt = rcnt_r - 1'b1;
        st_nxt = (rcnt_r == RW'(1)) ? B_NSEG : B_ROWSZ;
        raddr = p_nxt;
      end
      B_NSEG: begin
        raddr = p_r + AW'(1);
        p_nxt = p_r + AW'(2);
        st_nxt = B_SEGST;
      end
      B_SEGST: begin
        // rdata is segment count on first entry
        raddr = p_r;
        nseg_nxt = rdata_r;
        st_nxt = B_SEGCNT;
        if (rdata_r == '0) begin
          st_nxt = B_DONE;
        end
      end
      B_SEGCNT: begin
        start_nxt = rdata_r;
        raddr = p_r + AW'(1);
        st_nxt = B_SEGDEC;
      end
      B_SEGDEC: begin
        // rdata is the pixel count
        p_nxt = p_r + AW'(rdata_r) + AW'(2);
        nseg_nxt = nseg_r - 1'b1;
        n_nxt = '0;
        st_nxt = (nseg_r == 16'd1) ? B_DONE : B_SEGCNT;
        raddr = p_nxt;
        if (sx <= se) begin
          if (sx + sw < ss) begin
            st_nxt = B_DONE;
          end else begin
            if (ss == sx) begin
              dst_nxt = p_r + AW'(2);
              sn = (sw <= sc) ? sw : sc;
            end else if (sx < ss) begin
              dst_nxt = p_r + AW'(2);
              sn = (left <= sc) ? left : sc;
            end else begin
              dst_nxt = p_r + AW'(2) + AW'(sx - ss);
              sn = (se <= sx + sw) ? se - sx : sw;
            end
            if (sn > 0) begin
              n_nxt = sn[15:0];
              raddr = dst_nxt;
              st_nxt = B_PXWR;
            end
          end
        end
      end
      B_PXRD: begin
        raddr = dst_r; st_nxt = B_PXWR;
      end
      B_PXWR: begin
        wen = 1'b1;
        if (done_r != COUNT_MAX) done_nxt = done_r + 1'b1;
        dst_nxt = dst_r + 1'b1;
        n_nxt = n_r - 1'b1;
        if (n_r == 16'd1) begin
          raddr = p_r;
          st_nxt = (nseg_r == '0) ? B_DONE : B_SEGCNT;
        end else begin
          st_nxt = B_PXRD;
        end
      end
      B_DONE: begin
        ov_nxt = 1'b1; os_nxt = ST_DARK; od_nxt = '0; oc_nxt = done_r;
        st_nxt = B_IDLE;
      end
      default: st_nxt = B_IDLE;
    endcase
  end
endmodule

[hw/rtl/rssd_queue.sv]
// two-entry job queue between front and back
module rssd_queue import rssd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  output logic pop_valid,
  output job_t pop_job,
  input  logic pop
);
  job_t q_r [2];
  logic [1:0] cnt_r;
  logic rp_r, wp_r;
  logic do_pop;
  assign full = cnt_r[1];
  assign pop_valid = cnt_r != '0;
  assign pop_job = q_r[rp_r];
  assign do_pop = pop && pop_valid;
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_job;
    if (!rst_n) begin
      cnt_r <= '0; rp_r <= 1'b0; wp_r <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(do_pop);
    end
  end
endmodule

[hw/rtl/rle_sprite_span_darken.sv]
// top level: sprite span darkener with decoupled front, queue and back
//   channel   ports                                   transfer
//   in        start/busy, opcode..span_width          start && !busy
//   out       out_valid, out_status..pixels_changed   out_valid, one cycle
//   cfg       cfg_we, cfg_index, cfg_data             cfg_we
// after reset the row marks are cleared with busy high
// the front accepts an item, then does the mark lookup and push before it takes the next
// a darken walk's time grows with each row before the target, each segment
// and each darkened pixel (memory port bound)
// synchronous active-low reset clears the control and config registers and the queue
// busy is high during the clear, the mark lookup and while the queue is full
module rle_sprite_span_darken import rssd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_word_addr,
  input  logic [15:0] in_word_data,
  input  logic [11:0] in_row_index,
  input  logic [12:0] in_x_start,
  input  logic [12:0] in_span_width,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_read_data,
  output logic [11:0] out_pixels_changed,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  logic [11:0] fw_r;
  logic [10:0] fh_r;
  logic sp_r;
  logic jv, full, qv, qready, fready;
  job_t fj, qj;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= '0; fh_r <= '0; sp_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:   fw_r <= cfg_data;
        CFG_HEIGHT:  fh_r <= cfg_data[10:0];
        CFG_PRESENT: sp_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign busy = !fready || full;

  rssd_front u_front (
    .clk, .rst_n, .in_valid(start && !busy), .in_ready(fready), .opcode(in_opcode),
    .word_addr(in_word_addr), .word_data(in_word_data), .row_index(in_row_index),
    .x_start(in_x_start), .span_width(in_span_width), .field_width(fw_r),
    .field_height(fh_r), .sprite_present(sp_r), .job_valid(jv), .job(fj)
  );

  rssd_queue u_queue (
    .clk, .rst_n, .push(jv), .push_job(fj), .full, .pop_valid(qv),
    .pop_job(qj), .pop(qready)
  );

  rssd_back u_back (
    .clk, .rst_n, .job_valid(qv), .job(qj), .job_ready(qready), .out_valid,
    .out_status, .out_read_data, .out_pixels_changed
  );
endmodule
